/* hdl/fpa_pkg.sv */
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared types, operation codes and constants of the fixed-point ALU.
// ----------------------------------------------------------------------------
package fpa_pkg;

  localparam int unsigned FracBitsDef  = 8;
  localparam int unsigned DataWidthDef = 32;
  localparam int unsigned ActWidth     = 4;

  typedef enum logic [ActWidth-1:0] {
    OP_ADD     = 4'd0,
    OP_SUB     = 4'd1,
    OP_MUL     = 4'd2,
    OP_DIV     = 4'd3,
    OP_GT      = 4'd4,
    OP_LT      = 4'd5,
    OP_GE      = 4'd6,
    OP_LE      = 4'd7,
    OP_EQ      = 4'd8,
    OP_NE      = 4'd9,
    OP_MIN     = 4'd10,
    OP_MAX     = 4'd11,
    OP_INC     = 4'd12,
    OP_DEC     = 4'd13,
    OP_INT2FIX = 4'd14,
    OP_FIX2INT = 4'd15
  } op_e;

endpackage

/* hdl/fpa_div_cell.sv */
// ----------------------------------------------------------------------------
// fpa_div_cell
// One restoring-division cell: shift in one dividend bit, trial subtract.
// ----------------------------------------------------------------------------
module fpa_div_cell #(
  parameter int unsigned W  = 32,
  parameter int unsigned NW = 40
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [W-1:0]  rem_i,
  input  logic [NW-1:0] num_i,
  input  logic [W-1:0]  den_i,
  output logic [W-1:0]  rem_o,
  output logic [NW-1:0] num_o
);
  logic [W:0]    trial;
  logic [W:0]    diff;
  logic          take;
  logic [W-1:0]  rem_d;
  logic [NW-1:0] num_d;
  logic [W-1:0]  rem_q;
  logic [NW-1:0] num_q;

  always_comb begin
    trial = {rem_i, num_i[NW-1]};
    diff  = trial - {1'b0, den_i};
    take  = (trial >= {1'b0, den_i});
    rem_d = take ? diff[W-1:0] : trial[W-1:0];
    num_d = {num_i[NW-2:0], take};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      num_q <= num_d;
    end
  end

  assign rem_o = rem_q;
  assign num_o = num_q;
endmodule

/* hdl/fpa_mul_cell.sv */
// ----------------------------------------------------------------------------
// fpa_mul_cell
// One shift-add multiplier cell: add a partial product for one multiplier
// bit and pass the operands on.
// ----------------------------------------------------------------------------
module fpa_mul_cell #(
  parameter int unsigned W = 32,
  parameter int unsigned K = 0
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic [2*W-1:0] acc_i,
  input  logic [W-1:0]   mc_i,
  input  logic [W-1:0]   mp_i,
  output logic [2*W-1:0] acc_o,
  output logic [W-1:0]   mc_o,
  output logic [W-1:0]   mp_o
);
  logic [2*W-1:0] pp;
  logic [2*W-1:0] acc_q;
  logic [W-1:0]   mc_q;
  logic [W-1:0]   mp_q;

  assign pp = mp_i[K] ? ({{W{1'b0}}, mc_i} << K) : '0;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      acc_q <= acc_i + pp;
      mc_q  <= mc_i;
      mp_q  <= mp_i;
    end
  end

  assign acc_o = acc_q;
  assign mc_o  = mc_q;
  assign mp_o  = mp_q;
endmodule

/* hdl/fixed_point_alu_q24_8.sv */
// ----------------------------------------------------------------------------
// fixed_point_alu_q24_8
// Signed fixed-point ALU: add/sub, multiply, divide, compares, min/max,
// inc/dec and int/fixed conversion, pipelined through a chain of cells.
// ----------------------------------------------------------------------------
//  channel | signals                                        | direction
//  in      | in_valid_i, in_stall_o, action_i, operand_*_i  | into block
//  out     | out_valid_o, out_stall_i, result_value_o, ...  | out of block
//
//  Every operation has the same latency: the divider chain (one cell per
//  quotient bit) sets it; the multiplier chain (DATA_WIDTH cells) is padded
//  to match. One transfer per clock while out_stall_i does not hold the pipe.
//  The whole pipeline advances as one unit; out_stall_i holds it when the
//  output register is full, and in_stall_o is that same hold.
//  Reset clears the valid bits and the side band; operand, chain and output
//  payload registers are not reset.
// ----------------------------------------------------------------------------
module fixed_point_alu_q24_8 #(
  parameter int unsigned FRAC_BITS  = fpa_pkg::FracBitsDef,
  parameter int unsigned DATA_WIDTH = fpa_pkg::DataWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [fpa_pkg::ActWidth-1:0]  action_i,
  input  logic signed [DATA_WIDTH-1:0]  operand_a_i,
  input  logic signed [DATA_WIDTH-1:0]  operand_b_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [DATA_WIDTH-1:0]  result_value_o,
  output logic                          compare_true_o,
  output logic                          divide_by_zero_o
);
  import fpa_pkg::*;

  localparam int unsigned W   = DATA_WIDTH;
  localparam int unsigned NW  = W + FRAC_BITS;
  localparam int unsigned LAT = NW + 1;  // stage 0 + NW cells

  typedef struct packed {
    logic          vld;
    logic [W-1:0]  res;   // result of the simple ops
    logic          cmp;
    logic          neg;
    logic          dz;
    op_e           op;
  } side_t;

  logic adv;
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  // ---- stage 0: simple ops and operand magnitudes --------------------------
  logic [W-1:0] a, b, ma, mb;
  logic         lt_ab, lt_ba;
  side_t        s0;
  op_e          op_in;

  always_comb begin
    op_in = op_e'(action_i);
    a     = operand_a_i;
    b     = operand_b_i;
    ma    = a[W-1] ? (~a + 1'b1) : a;
    mb    = b[W-1] ? (~b + 1'b1) : b;
    lt_ab = $signed(a) < $signed(b);
    lt_ba = $signed(b) < $signed(a);
    s0.vld = in_valid_i;
    s0.op  = op_in;
    s0.neg = a[W-1] ^ b[W-1];
    s0.dz  = (op_in == OP_DIV) && (b == '0);
    s0.cmp = 1'b0;
    s0.res = '0;
    case (op_in)
      OP_ADD:     s0.res = a + b;
      OP_SUB:     s0.res = a - b;
      OP_GT:      s0.cmp = lt_ba;
      OP_LT:      s0.cmp = lt_ab;
      OP_GE:      s0.cmp = !lt_ab;
      OP_LE:      s0.cmp = !lt_ba;
      OP_EQ:      s0.cmp = (a == b);
      OP_NE:      s0.cmp = (a != b);
      OP_MIN:     s0.res = lt_ab ? a : b;
      OP_MAX:     s0.res = lt_ba ? a : b;
      OP_INC:     s0.res = a + 1'b1;
      OP_DEC:     s0.res = a - 1'b1;
      OP_INT2FIX: s0.res = a << FRAC_BITS;
      OP_FIX2INT: s0.res = W'($signed(a) >>> FRAC_BITS);
      default:    s0.res = '0;
    endcase
  end

  // ---- side band shift line, one entry per stage ---------------------------
  side_t side_q [LAT];
  side_t side_d [LAT];

  always_comb begin
    side_d[0] = s0;
    for (int i = 1; i < LAT; i++) side_d[i] = side_q[i-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LAT; i++) side_q[i] <= '0;
    end else if (adv) begin
      for (int i = 0; i < LAT; i++) side_q[i] <= side_d[i];
    end
  end

  // ---- stage 0 registers for the operand magnitudes ------------------------
  logic [W-1:0] ma_q, mb_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      ma_q <= ma;
      mb_q <= mb;
    end
  end

  // ---- divider chain: one cell per quotient bit ----------------------------
  logic [W-1:0]  drem [NW+1];
  logic [NW-1:0] dnum [NW+1];
  logic [W-1:0]  dden [NW+1];
  assign drem[0] = '0;
  assign dnum[0] = {ma_q, {FRAC_BITS{1'b0}}};
  assign dden[0] = mb_q;

  for (genvar k = 0; k < NW; k++) begin : g_div
    logic [W-1:0] den_q;
    fpa_div_cell #(.W(W), .NW(NW)) u_cell (
      .clk_i (clk_i),
      .en_i  (adv),
      .rem_i (drem[k]),
      .num_i (dnum[k]),
      .den_i (dden[k]),
      .rem_o (drem[k+1]),
      .num_o (dnum[k+1])
    );
    always_ff @(posedge clk_i) begin
      if (adv) den_q <= dden[k];
    end
    assign dden[k+1] = den_q;
  end

  // ---- multiplier chain: one cell per multiplier bit, then delay -----------
  logic [2*W-1:0] macc [W+1];
  logic [W-1:0]   mmc  [W+1];
  logic [W-1:0]   mmp  [W+1];
  assign macc[0] = '0;
  assign mmc[0]  = ma_q;
  assign mmp[0]  = mb_q;

  for (genvar k = 0; k < W; k++) begin : g_mul
    fpa_mul_cell #(.W(W), .K(k)) u_cell (
      .clk_i (clk_i),
      .en_i  (adv),
      .acc_i (macc[k]),
      .mc_i  (mmc[k]),
      .mp_i  (mmp[k]),
      .acc_o (macc[k+1]),
      .mc_o  (mmc[k+1]),
      .mp_o  (mmp[k+1])
    );
  end

  // pad the truncated product up to the divider depth
  logic [W-1:0] mq_q [FRAC_BITS];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      mq_q[0] <= W'(macc[W] >> FRAC_BITS);
      for (int i = 1; i < FRAC_BITS; i++) mq_q[i] <= mq_q[i-1];
    end
  end

  // ---- final select and output register ------------------------------------
  side_t        fin;
  logic [W-1:0] mag, sel;
  always_comb begin
    fin = side_q[LAT-1];
    mag = (fin.op == OP_MUL) ? mq_q[FRAC_BITS-1] : dnum[NW][W-1:0];
    sel = fin.res;
    if (fin.op == OP_MUL || (fin.op == OP_DIV && !fin.dz)) begin
      sel = fin.neg ? (~mag + 1'b1) : mag;
    end
  end

  logic         ovld_q;
  logic [W-1:0] ores_q;
  logic         ocmp_q, odz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ovld_q <= 1'b0;
    else if (adv) ovld_q <= fin.vld;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ores_q <= sel;
      ocmp_q <= fin.cmp;
      odz_q  <= fin.dz;
    end
  end

  assign out_valid_o      = ovld_q;
  assign result_value_o   = ores_q;
  assign compare_true_o   = ocmp_q;
  assign divide_by_zero_o = odz_q;

  // ---- assertions ----------------------------------------------------------
  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && divide_by_zero_o |-> result_value_o == '0)
    else $error("divide by zero gave nonzero result");

  a_cmp_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && compare_true_o |-> result_value_o == '0 && !divide_by_zero_o)
    else $error("compare result carries value");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(result_value_o))
    else $error("stalled output changed");

endmodule
